// File: hdl/eji_pkg.sv
package eji_pkg;

    typedef enum logic [1:0] {
        OP_WEIGHT  = 2'd0,
        OP_NODE    = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_DIMENSION  = 2'd0,
        REG_DOF_COUNT  = 2'd1,
        REG_QUAD_COUNT = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_ADJ,
        ST_DET,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam int DATA_W = 32;

    // Q16.16 product, round half up, result kept at full range
    function automatic logic signed [47:0] mul_q(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        p = p + 64'sd32768;
        return p[63:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] ext48(input logic signed [47:0] v);
        return {{16{v[47]}}, v};
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] x);
        return (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

endpackage

// File: hdl/eji_store.sv
module eji_store #(
    parameter int MAX_DOFS = 64,
    parameter int MAX_QUAD = 64,
    parameter int WADDR_W  = 14,
    parameter int NADDR_W  = 8
) (
    input  logic                aclk,
    input  logic                w_we,
    input  logic [WADDR_W-1:0]  w_waddr,
    input  logic [WADDR_W-1:0]  w_raddr,
    input  logic [31:0]         w_wdata,
    output logic [31:0]         w_rdata,
    input  logic                n_we,
    input  logic [NADDR_W-1:0]  n_waddr,
    input  logic [NADDR_W-1:0]  n_raddr,
    input  logic [31:0]         n_wdata,
    output logic [31:0]         n_rdata
);
    import eji_pkg::*;

    localparam int W_DEPTH = 3 * MAX_QUAD * MAX_DOFS;
    localparam int N_DEPTH = 3 * MAX_DOFS;

    logic [DATA_W-1:0] w_mem [0:W_DEPTH-1];
    logic [DATA_W-1:0] n_mem [0:N_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (w_we) begin
            w_mem[w_waddr] <= w_wdata;
        end
        w_rdata <= w_mem[w_raddr];
    end

    always_ff @(posedge aclk) begin
        if (n_we) begin
            n_mem[n_waddr] <= n_wdata;
        end
        n_rdata <= n_mem[n_raddr];
    end

endmodule

// File: hdl/eji_div.sv
module eji_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    import eji_pkg::*;

    logic        run_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [48:0] dvd_reg;
    logic [31:0] den_reg;
    logic        neg_reg;

    logic [32:0] num_abs;
    logic [32:0] den_abs;
    logic [32:0] rem_sh;
    logic        fits;

    assign num_abs = num[31] ? 33'd0 - {num[31], num} : {1'b0, num};
    assign den_abs = den[31] ? 33'd0 - {den[31], den} : {1'b0, den};
    assign rem_sh  = {rem_reg[31:0], dvd_reg[48]};
    assign fits    = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 6'd49;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle, rounding folded into the dividend
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= den_abs[31:0];
            neg_reg <= num[31] ^ den[31];
            dvd_reg <= {1'b0, num_abs[31:0], 16'd0} + {17'd0, den_abs[32:1]};
        end else if (run_reg) begin
            rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            dvd_reg <= {dvd_reg[47:0], fits};
        end
    end

    always_comb begin
        if (!neg_reg) begin
            quo = (dvd_reg > 49'h7fffffff) ? 32'sh7fffffff : dvd_reg[31:0];
        end else begin
            quo = (dvd_reg > 49'h80000000) ? 32'sh80000000 : 32'd0 - dvd_reg[31:0];
        end
    end

    assign done = done_reg;

endmodule

// File: hdl/element_jacobian_inverse_top.sv
// channel  | handshake          | payload
// s_       | s_valid / s_ready  | opcode, axis, quad_index, dof_index, data_value
// m_       | m_valid / m_ready  | quad_point, row, jac/inv columns, determinant, flags
// cfg_     | cfg_we             | cfg_index, cfg_data
// load items are written to the weight or node memory on acceptance
// compute walks the multiply-accumulate through the memory port, then forms the adjugate,
// the determinant, the inverse through the serial divider (skipped when the determinant
// is zero) and the result rows
// synchronous active-low reset clears control and sets configuration to 3D, 8 dofs, 8 quads; memories are not cleared
// a stalled result holds the block; no item is taken until the last row is delivered
module element_jacobian_inverse_top #(
    parameter int MAX_DOFS = 64,
    parameter int MAX_QUAD = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [1:0]         s_axis,
    input  logic [5:0]         s_quad_index,
    input  logic [5:0]         s_dof_index,
    input  logic signed [31:0] s_data_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_quad_point,
    output logic [1:0]         m_row,
    output logic signed [31:0] m_jac_col0,
    output logic signed [31:0] m_jac_col1,
    output logic signed [31:0] m_jac_col2,
    output logic signed [31:0] m_inv_col0,
    output logic signed [31:0] m_inv_col1,
    output logic signed [31:0] m_inv_col2,
    output logic signed [31:0] m_determinant,
    output logic               m_singular,
    output logic               m_last_row,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data
);
    import eji_pkg::*;

    localparam int WADDR_W = $clog2(3 * MAX_QUAD * MAX_DOFS);
    localparam int NADDR_W = $clog2(3 * MAX_DOFS);
    localparam int K_W     = (MAX_DOFS > 1) ? $clog2(MAX_DOFS) : 1;
    localparam int ND_W    = $clog2(MAX_DOFS + 1);
    localparam int NQ_W    = $clog2(MAX_QUAD + 1);

    state_t state_reg, state_next;

    logic [1:0] dimension_reg;
    logic [6:0] dof_count_reg;
    logic [6:0] quad_count_reg;

    logic [ND_W-1:0] nd_eff;
    logic [NQ_W-1:0] nq_eff;
    logic            dims3;
    logic [1:0]      dims_last;

    logic [5:0]     q_reg;
    logic [1:0]     r_reg, c_reg, step_reg;
    logic [K_W-1:0] k_reg;
    logic           last_k;

    logic signed [31:0] j_reg   [0:2][0:2];
    logic signed [31:0] a_reg   [0:2][0:2];
    logic signed [31:0] inv_reg [0:2][0:2];
    logic signed [31:0] det_reg;
    logic signed [47:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_new;

    // multiply-accumulate pipeline tags: read data stage and product stage
    logic       v1_reg, first1_reg, last1_reg;
    logic [1:0] r1_reg, c1_reg;
    logic       v2_reg, first2_reg, last2_reg;
    logic [1:0] r2_reg, c2_reg;

    logic [WADDR_W-1:0] w_waddr, w_raddr;
    logic [NADDR_W-1:0] n_waddr, n_raddr;
    logic [31:0]        w_rdata, n_rdata;
    logic               w_we, n_we;

    logic               s_fire, m_fire, compute_ok;
    logic signed [31:0] opx, opy;
    logic signed [47:0] mul_res;
    logic [1:0]         cr1, cr2, rr1, rr2;
    logic signed [63:0] det_acc;
    logic               div_start, div_done;
    logic signed [31:0] div_quo;

    assign nd_eff    = (int'(dof_count_reg) > MAX_DOFS) ? ND_W'(MAX_DOFS) : ND_W'(dof_count_reg);
    assign nq_eff    = (int'(quad_count_reg) > MAX_QUAD) ? NQ_W'(MAX_QUAD) : NQ_W'(quad_count_reg);
    assign dims3     = dimension_reg == 2'd3;
    assign dims_last = dims3 ? 2'd2 : 2'd1;
    assign last_k    = int'(k_reg) == int'(nd_eff) - 1;

    assign s_ready    = state_reg == ST_IDLE;
    assign s_fire     = s_valid && s_ready;
    assign m_valid    = state_reg == ST_OUT;
    assign m_fire     = m_valid && m_ready;
    assign compute_ok = int'(s_quad_index) < int'(nq_eff);

    assign w_we    = s_fire && s_opcode == OP_WEIGHT && s_axis != 2'd3
                     && int'(s_quad_index) < MAX_QUAD && int'(s_dof_index) < MAX_DOFS;
    assign n_we    = s_fire && s_opcode == OP_NODE && s_axis != 2'd3
                     && int'(s_dof_index) < MAX_DOFS;
    assign w_waddr = WADDR_W'((int'(s_axis) * MAX_QUAD + int'(s_quad_index)) * MAX_DOFS
                              + int'(s_dof_index));
    assign n_waddr = NADDR_W'(int'(s_axis) * MAX_DOFS + int'(s_dof_index));
    assign w_raddr = WADDR_W'((int'(r_reg) * MAX_QUAD + int'(q_reg)) * MAX_DOFS + int'(k_reg));
    assign n_raddr = NADDR_W'(int'(c_reg) * MAX_DOFS + int'(k_reg));

    eji_store #(
        .MAX_DOFS (MAX_DOFS),
        .MAX_QUAD (MAX_QUAD),
        .WADDR_W  (WADDR_W),
        .NADDR_W  (NADDR_W)
    ) u_store (
        .aclk    (aclk),
        .w_we    (w_we),
        .w_waddr (w_waddr),
        .w_raddr (w_raddr),
        .w_wdata (s_data_value),
        .w_rdata (w_rdata),
        .n_we    (n_we),
        .n_waddr (n_waddr),
        .n_raddr (n_raddr),
        .n_wdata (s_data_value),
        .n_rdata (n_rdata)
    );

    assign div_start = state_reg == ST_DIV && step_reg == 2'd0;

    eji_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (a_reg[r_reg][c_reg]),
        .den     (det_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // operand selection for the shared multiplier
    assign cr1 = inc3(c_reg);
    assign cr2 = inc3(cr1);
    assign rr1 = inc3(r_reg);
    assign rr2 = inc3(rr1);

    always_comb begin
        opx = w_rdata;
        opy = n_rdata;
        case (state_reg)
            ST_ADJ: begin
                if (step_reg == 2'd0) begin
                    opx = j_reg[cr1][rr1];
                    opy = j_reg[cr2][rr2];
                end else begin
                    opx = j_reg[cr1][rr2];
                    opy = j_reg[cr2][rr1];
                end
            end
            ST_DET: begin
                opx = j_reg[0][r_reg];
                if (dims3) begin
                    opy = a_reg[r_reg][0];
                end else begin
                    opy = (r_reg == 2'd0) ? j_reg[1][1] : j_reg[1][0];
                end
            end
            default: ;
        endcase
    end

    assign mul_res = mul_q(opx, opy);
    assign acc_new = first2_reg ? ext48(prod_reg) : acc_reg + ext48(prod_reg);
    // 2D second term is subtracted; first term restarts the sum
    assign det_acc = ((r_reg == 2'd0) ? 64'sd0 : acc_reg)
                     + ((!dims3 && r_reg == 2'd1) ? -ext48(prod_reg) : ext48(prod_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_opcode == OP_COMPUTE && compute_ok) begin
                    state_next = (nd_eff == '0) ? ST_ADJ : ST_MAC;
                end
            end
            ST_MAC: begin
                if (last_k && c_reg == dims_last && r_reg == dims_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ: begin
                if (!dims3 || (step_reg == 2'd2 && r_reg == 2'd2 && c_reg == 2'd2)) begin
                    state_next = ST_DET;
                end
            end
            ST_DET: begin
                if (step_reg == 2'd1 && r_reg == dims_last) begin
                    state_next = (sat32(det_acc) == 32'sd0) ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_reg == 2'd1 && div_done && r_reg == dims_last
                    && c_reg == dims_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_fire && r_reg == dims_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dimension_reg  <= 2'd3;
            dof_count_reg  <= 7'd8;
            quad_count_reg <= 7'd8;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DIMENSION:  dimension_reg  <= cfg_data[1:0];
                REG_DOF_COUNT:  dof_count_reg  <= cfg_data;
                REG_QUAD_COUNT: quad_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // walk counters, restarted on every change of state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg    <= '0;
            c_reg    <= '0;
            k_reg    <= '0;
            step_reg <= '0;
        end else if (state_next != state_reg) begin
            r_reg    <= '0;
            c_reg    <= '0;
            k_reg    <= '0;
            step_reg <= '0;
        end else begin
            case (state_reg)
                ST_MAC: begin
                    if (last_k) begin
                        k_reg <= '0;
                        if (c_reg == dims_last) begin
                            c_reg <= '0;
                            r_reg <= r_reg + 2'd1;
                        end else begin
                            c_reg <= c_reg + 2'd1;
                        end
                    end else begin
                        k_reg <= k_reg + K_W'(1);
                    end
                end
                ST_ADJ: begin
                    if (step_reg == 2'd2) begin
                        step_reg <= '0;
                        if (c_reg == 2'd2) begin
                            c_reg <= '0;
                            r_reg <= r_reg + 2'd1;
                        end else begin
                            c_reg <= c_reg + 2'd1;
                        end
                    end else begin
                        step_reg <= step_reg + 2'd1;
                    end
                end
                ST_DET: begin
                    if (step_reg == 2'd1) begin
                        step_reg <= '0;
                        r_reg    <= r_reg + 2'd1;
                    end else begin
                        step_reg <= 2'd1;
                    end
                end
                ST_DIV: begin
                    if (step_reg == 2'd0) begin
                        step_reg <= 2'd1;
                    end else if (div_done) begin
                        step_reg <= '0;
                        if (c_reg == dims_last) begin
                            c_reg <= '0;
                            r_reg <= r_reg + 2'd1;
                        end else begin
                            c_reg <= c_reg + 2'd1;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_fire) begin
                        r_reg <= r_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= state_reg == ST_MAC;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        first1_reg <= k_reg == '0;
        last1_reg  <= last_k;
        r1_reg     <= r_reg;
        c1_reg     <= c_reg;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        r2_reg     <= r1_reg;
        c2_reg     <= c1_reg;

        if (v1_reg || state_reg == ST_ADJ || state_reg == ST_DET) begin
            prod_reg <= mul_res;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_opcode == OP_COMPUTE) begin
                    q_reg <= s_quad_index;
                    for (int i = 0; i < 3; i++) begin
                        for (int j = 0; j < 3; j++) begin
                            j_reg[i][j]   <= '0;
                            a_reg[i][j]   <= '0;
                            inv_reg[i][j] <= '0;
                        end
                    end
                end
            end
            ST_ADJ: begin
                if (!dims3) begin
                    a_reg[0][0] <= j_reg[1][1];
                    a_reg[0][1] <= sat32(64'sd0 - {{32{j_reg[0][1][31]}}, j_reg[0][1]});
                    a_reg[1][0] <= sat32(64'sd0 - {{32{j_reg[1][0][31]}}, j_reg[1][0]});
                    a_reg[1][1] <= j_reg[0][0];
                end else if (step_reg == 2'd1) begin
                    acc_reg <= ext48(prod_reg);
                end else if (step_reg == 2'd2) begin
                    a_reg[r_reg][c_reg] <= sat32(acc_reg - ext48(prod_reg));
                end
            end
            ST_DET: begin
                if (step_reg == 2'd1) begin
                    acc_reg <= det_acc;
                    det_reg <= sat32(det_acc);
                end
            end
            ST_DIV: begin
                if (step_reg == 2'd1 && div_done) begin
                    inv_reg[r_reg][c_reg] <= div_quo;
                end
            end
            default: ;
        endcase

        if (v2_reg) begin
            acc_reg <= acc_new;
            if (last2_reg) begin
                j_reg[r2_reg][c2_reg] <= sat32(acc_new);
            end
        end
    end

    assign m_quad_point  = q_reg;
    assign m_row         = r_reg;
    assign m_jac_col0    = j_reg[r_reg][0];
    assign m_jac_col1    = j_reg[r_reg][1];
    assign m_jac_col2    = j_reg[r_reg][2];
    assign m_inv_col0    = inv_reg[r_reg][0];
    assign m_inv_col1    = inv_reg[r_reg][1];
    assign m_inv_col2    = inv_reg[r_reg][2];
    assign m_determinant = det_reg;
    assign m_singular    = det_reg == 32'sd0;
    assign m_last_row    = r_reg == dims_last;

`ifndef ASSERT_OFF
    a_compute_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_opcode == OP_COMPUTE && compute_ok) |=> !s_ready)
        else $error("input taken while an item is in work");

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_singular) |->
        (m_inv_col0 == 32'sd0 && m_inv_col1 == 32'sd0 && m_inv_col2 == 32'sd0))
        else $error("singular row with nonzero inverse");

    a_pipe_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (state_reg == ST_MAC || state_reg == ST_FLUSH))
        else $error("accumulate still in flight after the walk");

    a_last_row_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_last_row) |=> s_ready)
        else $error("block not free after the final row");
`endif

endmodule

// File: sim/tb_element_jacobian_inverse_top.sv
`timescale 1ns / 1ps

module tb_element_jacobian_inverse_top;
    import eji_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [1:0] AXIS_NONE   = 2'd3;
    localparam logic [1:0] REG_NONE    = 2'd3;
    localparam int SETTLE_CYCLES = 1300;

    typedef struct {
        logic [5:0]  quad_point;
        logic [1:0]  row;
        logic [31:0] jac [3];
        logic [31:0] inv [3];
        logic [31:0] det;
        logic        singular;
        logic        last_row;
    } jac_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_opcode;
    logic [1:0]         s_axis;
    logic [5:0]         s_quad_index;
    logic [5:0]         s_dof_index;
    logic signed [31:0] s_data_value;
    logic               m_valid;
    logic               m_ready;
    logic [5:0]         m_quad_point;
    logic [1:0]         m_row;
    logic signed [31:0] m_jac_col0, m_jac_col1, m_jac_col2;
    logic signed [31:0] m_inv_col0, m_inv_col1, m_inv_col2;
    logic signed [31:0] m_determinant;
    logic               m_singular;
    logic               m_last_row;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [6:0]         cfg_data;

    element_jacobian_inverse_top dut (.*);

    // shadow state of the block
    int       weight_mem [3][64][64];
    bit       weight_set [3][64][64];
    int       node_mem [3][64];
    bit       node_set [3][64];
    logic [1:0] cur_dimension;
    logic [6:0] cur_dofs;
    logic [6:0] cur_quads;

    jac_row_t expected_rows [$];
    int       error_count;
    int       idle_pct;
    int       stall_pct;
    int       hold_count;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint qmul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic int qdiv(int n, int d);
        longint un, ud, qq;
        un = (n < 0 ? -longint'(n) : longint'(n)) << 16;
        ud = d < 0 ? -longint'(d) : longint'(d);
        qq = (un + ud / 2) / ud;
        return clamp32(((n < 0) != (d < 0)) ? -qq : qq);
    endfunction

    function automatic int dims_now();
        return (cur_dimension == 2'd3) ? 3 : 2;
    endfunction

    function automatic int dofs_now();
        return (cur_dofs > 7'd64) ? 64 : int'(cur_dofs);
    endfunction

    function automatic int quads_now();
        return (cur_quads > 7'd64) ? 64 : int'(cur_quads);
    endfunction

    // jacobian, adjugate, determinant and inverse rows for one quad point
    function automatic void predict_rows(int q);
        int       jm [3][3];
        int       adj [3][3];
        int       im [3][3];
        int       det, nd, dm;
        longint   acc;
        jac_row_t e;
        nd = dofs_now();
        dm = dims_now();
        jm = '{default: 0};
        adj = '{default: 0};
        im = '{default: 0};
        for (int r = 0; r < dm; r++) begin
            for (int c = 0; c < dm; c++) begin
                acc = 0;
                for (int k = 0; k < nd; k++) begin
                    acc += qmul(weight_mem[r][q][k], node_mem[c][k]);
                end
                jm[r][c] = clamp32(acc);
            end
        end
        if (dm == 2) begin
            adj[0][0] = jm[1][1];
            adj[0][1] = clamp32(-longint'(jm[0][1]));
            adj[1][0] = clamp32(-longint'(jm[1][0]));
            adj[1][1] = jm[0][0];
            det = clamp32(qmul(jm[0][0], jm[1][1]) - qmul(jm[0][1], jm[1][0]));
        end else begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    adj[r][c] = clamp32(qmul(jm[(c+1)%3][(r+1)%3], jm[(c+2)%3][(r+2)%3])
                                      - qmul(jm[(c+1)%3][(r+2)%3], jm[(c+2)%3][(r+1)%3]));
                end
            end
            det = clamp32(qmul(jm[0][0], adj[0][0]) + qmul(jm[0][1], adj[1][0])
                        + qmul(jm[0][2], adj[2][0]));
        end
        if (det != 0) begin
            for (int r = 0; r < dm; r++) begin
                for (int c = 0; c < dm; c++) begin
                    im[r][c] = qdiv(adj[r][c], det);
                end
            end
        end
        for (int r = 0; r < dm; r++) begin
            e.quad_point = q[5:0];
            e.row = r[1:0];
            for (int c = 0; c < 3; c++) begin
                e.jac[c] = jm[r][c];
                e.inv[c] = im[r][c];
            end
            e.det = det;
            e.singular = (det == 0);
            e.last_row = (r == dm - 1);
            expected_rows.push_back(e);
        end
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2, 3: return int'($urandom);
            default: return int'($urandom_range(0, 262143)) - 131072;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        jac_row_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                report_mismatch("unexpected row", {30'd0, m_row}, 32'd0);
            end else begin
                e = expected_rows.pop_front();
                if (m_quad_point != e.quad_point) report_mismatch("quad_point", m_quad_point, e.quad_point);
                if (m_row != e.row) report_mismatch("row", m_row, e.row);
                if (m_jac_col0 != e.jac[0]) report_mismatch("jac_col0", m_jac_col0, e.jac[0]);
                if (m_jac_col1 != e.jac[1]) report_mismatch("jac_col1", m_jac_col1, e.jac[1]);
                if (m_jac_col2 != e.jac[2]) report_mismatch("jac_col2", m_jac_col2, e.jac[2]);
                if (m_inv_col0 != e.inv[0]) report_mismatch("inv_col0", m_inv_col0, e.inv[0]);
                if (m_inv_col1 != e.inv[1]) report_mismatch("inv_col1", m_inv_col1, e.inv[1]);
                if (m_inv_col2 != e.inv[2]) report_mismatch("inv_col2", m_inv_col2, e.inv[2]);
                if (m_determinant != e.det) report_mismatch("determinant", m_determinant, e.det);
                if (m_singular != e.singular) report_mismatch("singular", m_singular, e.singular);
                if (m_last_row != e.last_row) report_mismatch("last_row", m_last_row, e.last_row);
            end
        end
    end

    // receiver, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_count > 0) begin
            m_ready <= 1'b0;
            hold_count--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_item(logic [1:0] op, logic [1:0] axis, logic [5:0] q, logic [5:0] d,
                             int value);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_axis       <= axis;
        s_quad_index <= q;
        s_dof_index  <= d;
        s_data_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_WEIGHT && axis != AXIS_NONE) begin
            weight_mem[axis][q][d] = value;
            weight_set[axis][q][d] = 1'b1;
        end else if (op == OP_NODE && axis != AXIS_NONE) begin
            node_mem[axis][d] = value;
            node_set[axis][d] = 1'b1;
        end else if (op == OP_COMPUTE && q < quads_now()) begin
            predict_rows(q);
        end
        @(negedge aclk);
    endtask

    // compute item, after loading any entry it would read that was never written
    task automatic compute_quad(int q);
        if (q < quads_now()) begin
            for (int k = 0; k < dofs_now(); k++) begin
                for (int a = 0; a < dims_now(); a++) begin
                    if (!weight_set[a][q][k]) send_item(OP_WEIGHT, a, q, k, rand_value());
                    if (!node_set[a][k]) send_item(OP_NODE, a, 0, k, rand_value());
                end
            end
        end
        send_item(OP_COMPUTE, $urandom_range(0, 3), q, $urandom, int'($urandom));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_rows.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_DIMENSION) cur_dimension = value[1:0];
        else if (idx == REG_DOF_COUNT) cur_dofs = value;
        else if (idx == REG_QUAD_COUNT) cur_quads = value;
    endtask

    task automatic test_reset_settings();
        compute_quad(0);
        send_item(OP_WEIGHT, 0, 7, 0, 32'sh7fffffff);
        send_item(OP_NODE, 0, 0, 0, 32'sh80000000);
        compute_quad(7);
        // beyond the quad count: nothing comes back
        compute_quad(8);
        compute_quad(63);
        send_item(OP_WEIGHT, 2, 63, 63, 32'sh7fffffff);
        send_item(OP_NODE, 2, 0, 63, 32'sh80000000);
    endtask

    task automatic test_ignored_items();
        send_item(OP_RESERVED, 2, 0, 0, int'($urandom));
        send_item(OP_WEIGHT, AXIS_NONE, 0, 0, int'($urandom));
        send_item(OP_NODE, AXIS_NONE, 0, 1, int'($urandom));
        compute_quad(0);
        write_reg(REG_NONE, 7'h7f);
        compute_quad(1);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_DIMENSION, 7'd2);
        compute_quad(2);
        write_reg(REG_DIMENSION, 7'd0);
        compute_quad(3);
        write_reg(REG_DIMENSION, 7'd1);
        // nothing accumulated: singular
        write_reg(REG_DOF_COUNT, 7'd0);
        compute_quad(0);
        write_reg(REG_DIMENSION, 7'd3);
        compute_quad(0);
        write_reg(REG_DOF_COUNT, 7'd1);
        compute_quad(4);
        write_reg(REG_QUAD_COUNT, 7'd0);
        compute_quad(0);
        write_reg(REG_QUAD_COUNT, 7'd127);
        write_reg(REG_DOF_COUNT, 7'd127);
        compute_quad(63);
        write_reg(REG_DOF_COUNT, 7'd64);
        write_reg(REG_QUAD_COUNT, 7'd64);
        compute_quad(63);
        write_reg(REG_QUAD_COUNT, 7'd1);
        write_reg(REG_DOF_COUNT, 7'd2);
        compute_quad(0);
        compute_quad(1);
    endtask

    task automatic test_random_traffic(int n_items);
        int pick;
        write_reg(REG_DIMENSION, $urandom_range(0, 3));
        write_reg(REG_DOF_COUNT, $urandom_range(1, 6));
        write_reg(REG_QUAD_COUNT, $urandom_range(1, 8));
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                compute_quad($urandom_range(0, quads_now() - 1));
            end else if (pick < 8) begin
                send_item($urandom_range(0, 1), $urandom_range(0, 2), $urandom, $urandom,
                          rand_value());
            end else if (pick == 8) begin
                send_item(OP_RESERVED, $urandom, $urandom, $urandom, int'($urandom));
            end else begin
                compute_quad($urandom_range(quads_now(), 63));
            end
        end
    endtask

    task automatic test_output_backpressure();
        write_reg(REG_DIMENSION, 7'd3);
        write_reg(REG_DOF_COUNT, 7'd4);
        write_reg(REG_QUAD_COUNT, 7'd4);
        for (int q = 0; q < 4; q++) compute_quad(q);
        drain_results();
        @(posedge aclk);
        hold_count = 800;
        @(negedge aclk);
        for (int q = 0; q < 4; q++) compute_quad(q);
        drain_results();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_WEIGHT;
        s_axis = 2'd0;
        s_quad_index = 6'd0;
        s_dof_index = 6'd0;
        s_data_value = 32'sd0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DIMENSION;
        cfg_data = 7'd0;
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_count = 0;
        cur_dimension = 2'd3;
        cur_dofs = 7'd8;
        cur_quads = 7'd8;
        weight_set = '{default: 1'b0};
        node_set = '{default: 1'b0};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_settings();
        test_ignored_items();
        test_register_extremes();
        idle_pct = 0;  stall_pct = 0;  test_random_traffic(28);
        idle_pct = 53; stall_pct = 0;  test_random_traffic(28);
        idle_pct = 0;  stall_pct = 53; test_random_traffic(28);
        idle_pct = 34; stall_pct = 34; test_random_traffic(28);
        test_output_backpressure();

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (error_count == 0 && expected_rows.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
hdl/eji_pkg.sv
hdl/eji_store.sv
hdl/eji_div.sv
hdl/element_jacobian_inverse_top.sv
sim/tb_element_jacobian_inverse_top.sv
